// ===== rtl/ofd_pkg.sv =====
// Package for the odometry frame deframer: constants, state and command types.
package ofd_pkg;
  localparam int FrameLen = 22;
  localparam int CrcSpan = 20;
  localparam logic [7:0] SyncLo = 8'h55;
  localparam logic [7:0] SyncHi = 8'hAA;
  localparam logic [7:0] ProtoVersion = 8'h01;
  localparam logic [7:0] MsgType = 8'h01;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [31:0] DtLimitReset = 32'd1000000;

  localparam logic [1:0] RegLeftNegate = 2'd0;
  localparam logic [1:0] RegRightNegate = 2'd1;
  localparam logic [1:0] RegDtLimit = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_CRC, ST_VERDICT, ST_OUT
  } ofd_state_t;

  typedef struct packed {
    logic shift_in;   // store accepted byte
    logic crc_start;  // load CRC init, zero index
    logic crc_step;   // fold one byte
    logic drop;       // drop oldest byte
    logic hdr_rej;    // count header reject
    logic crc_bad;    // count CRC failure
    logic take;       // commit good frame, load outputs
  } ofd_cmd_t;

  typedef struct packed {
    logic full;
    logic sync_ok;
    logic hdr_ok;
    logic crc_done;
    logic crc_ok;
  } ofd_stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction
endpackage

// ===== rtl/ofd_ctrl.sv =====
// Controller state machine for the frame deframer.
module ofd_ctrl import ofd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ofd_stat_t stat,
  output ofd_cmd_t  cmd
);
  ofd_state_t state, state_next;
  logic out_pend, out_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_pend <= 1'b0;
    end else begin
      state <= state_next;
      out_pend <= out_pend_next;
    end
  end

  assign out_valid = out_pend;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_pend_next = out_pend && !out_ready;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.shift_in = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!stat.full) state_next = ST_IDLE;
        else if (!stat.sync_ok) begin
          cmd.drop = 1'b1;
          state_next = ST_IDLE;
        end else if (!stat.hdr_ok) begin
          cmd.hdr_rej = 1'b1;
          cmd.drop = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.crc_start = 1'b1;
          state_next = ST_CRC;
        end
      end
      ST_CRC: begin
        cmd.crc_step = 1'b1;
        if (stat.crc_done) state_next = ST_VERDICT;
      end
      ST_VERDICT: begin
        if (!stat.crc_ok) begin
          cmd.crc_bad = 1'b1;
          cmd.drop = 1'b1;
          state_next = ST_IDLE;
        end else state_next = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to free up
        if (!out_pend || out_ready) begin
          cmd.take = 1'b1;
          out_pend_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== rtl/ofd_datapath.sv =====
// Datapath: byte window, CRC walker, counters and output register.
module ofd_datapath import ofd_pkg::*; #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  rx_byte,
  input  ofd_cmd_t    cmd,
  output ofd_stat_t   stat,
  input  logic        left_negate,
  input  logic        right_negate,
  input  logic [31:0] dt_limit_us,
  output logic [31:0] frame_seq,
  output logic [31:0] frame_dt_us,
  output logic signed [31:0] left_ticks,
  output logic signed [31:0] right_ticks,
  output logic        seq_jumped,
  output logic        dt_usable,
  output logic [31:0] good_frames,
  output logic [31:0] crc_failures,
  output logic [31:0] header_rejects,
  output logic [31:0] seq_jump_total
);
  localparam int FillW = $clog2(FrameLen + 1);
  localparam int IdxW = $clog2(CrcSpan);

  logic [7:0] win [FrameLen];
  logic [FillW-1:0] fill;
  logic [IdxW-1:0] crc_idx;
  logic [15:0] crc;
  logic seq_seen;
  logic [31:0] previous_seq;
  logic [COUNTER_WIDTH-1:0] good_count, crc_bad_count, header_reject_count, jump_count;
  logic [COUNTER_WIDTH-1:0] good_next, jump_next;
  logic [31:0] seq_w, dt_w, lt_w, rt_w;
  logic jumped;

  assign seq_w = {win[7], win[6], win[5], win[4]};
  assign dt_w = {win[11], win[10], win[9], win[8]};
  assign lt_w = {win[15], win[14], win[13], win[12]};
  assign rt_w = {win[19], win[18], win[17], win[16]};
  assign jumped = seq_seen && (seq_w != previous_seq + 32'd1);
  assign good_next = good_count + 1'b1;
  assign jump_next = jumped ? jump_count + 1'b1 : jump_count;

  assign stat.full = (fill == FillW'(FrameLen));
  assign stat.sync_ok = (win[0] == SyncLo) && (win[1] == SyncHi);
  assign stat.hdr_ok = (win[2] == ProtoVersion) && (win[3] == MsgType);
  assign stat.crc_done = (crc_idx == IdxW'(CrcSpan - 1));
  assign stat.crc_ok = (crc == {win[21], win[20]});

  // window: byte write at fill point, one-place shift on drop
  always_ff @(posedge clk) begin
    if (cmd.shift_in) win[fill[FillW-1:0] == FillW'(FrameLen) ? 5'(FrameLen - 1)
                          : fill[4:0]] <= rx_byte;
    if (cmd.drop) begin
      for (int i = 0; i < FrameLen - 1; i++) win[i] <= win[i + 1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      seq_seen <= 1'b0;
      previous_seq <= '0;
      good_count <= '0;
      crc_bad_count <= '0;
      header_reject_count <= '0;
      jump_count <= '0;
    end else begin
      if (cmd.shift_in) fill <= fill + 1'b1;
      if (cmd.drop) fill <= FillW'(FrameLen - 1);
      if (cmd.hdr_rej) header_reject_count <= header_reject_count + 1'b1;
      if (cmd.crc_bad) crc_bad_count <= crc_bad_count + 1'b1;
      if (cmd.take) begin
        fill <= '0;
        good_count <= good_next;
        jump_count <= jump_next;
        seq_seen <= 1'b1;
        previous_seq <= seq_w;
      end
    end
  end

  // CRC walk, one window byte per cycle
  always_ff @(posedge clk) begin
    if (cmd.crc_start) begin
      crc <= CrcInit;
      crc_idx <= '0;
    end else if (cmd.crc_step) begin
      crc <= crc_byte(crc, win[crc_idx]);
      crc_idx <= crc_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      frame_seq <= seq_w;
      frame_dt_us <= dt_w;
      left_ticks <= left_negate ? 32'd0 - lt_w : lt_w;
      right_ticks <= right_negate ? 32'd0 - rt_w : rt_w;
      seq_jumped <= jumped;
      dt_usable <= (dt_w != '0) && (dt_w <= dt_limit_us);
      good_frames <= 32'(good_next);
      crc_failures <= 32'(crc_bad_count);
      header_rejects <= 32'(header_reject_count);
      seq_jump_total <= 32'(jump_next);
    end
  end
endmodule

// ===== rtl/odom_frame_deframer_crc16.sv =====
// Top level of the odometry frame deframer with CRC-16 check.
// Usage:
//  - rx channel (rx_valid/rx_ready, rx_byte) takes one received byte per
//    transfer; bytes build a 22-byte window.
//  - Once full, the window is checked: sync 0xAA55, version, type, then a
//    CRC-16-CCITT-FALSE over bytes 0..19 walked one byte per cycle.
//  - A good frame gives one transfer on the out channel and empties the
//    window; a bad one drops the oldest byte, counting header/CRC faults.
// A byte is taken only in ST_IDLE and checked in ST_CHECK; a byte that
// completes a valid-header window then goes through the byte-serial CRC
// walk (ST_CRC, 20 steps), ST_VERDICT and, on success, ST_OUT.
// Output: results sit in an output register; rx stays open while a result
// waits, and only a further good frame stalls until the receiver takes it.
// Reset (rst, synchronous): window empty, counters and sequence history
// cleared, dt_limit_us = 1000000, negates 0.
// Config: cfg_we/cfg_index/cfg_data, written only while idle (user's job).
module odom_frame_deframer_crc16 import ofd_pkg::*; #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] frame_seq,
  output logic [31:0] frame_dt_us,
  output logic signed [31:0] left_ticks,
  output logic signed [31:0] right_ticks,
  output logic        seq_jumped,
  output logic        dt_usable,
  output logic [31:0] good_frames,
  output logic [31:0] crc_failures,
  output logic [31:0] header_rejects,
  output logic [31:0] seq_jump_total
);
  logic left_negate, right_negate;
  logic [31:0] dt_limit_us;
  ofd_cmd_t cmd;
  ofd_stat_t stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      left_negate <= 1'b0;
      right_negate <= 1'b0;
      dt_limit_us <= DtLimitReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegLeftNegate:  left_negate <= cfg_data[0];
        RegRightNegate: right_negate <= cfg_data[0];
        RegDtLimit:     dt_limit_us <= cfg_data;
        default: ;
      endcase
    end
  end

  ofd_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(rx_valid), .in_ready(rx_ready),
    .out_valid, .out_ready,
    .stat, .cmd
  );

  ofd_datapath #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_dp (
    .clk, .rst, .rx_byte, .cmd, .stat,
    .left_negate, .right_negate, .dt_limit_us,
    .frame_seq, .frame_dt_us, .left_ticks, .right_ticks,
    .seq_jumped, .dt_usable, .good_frames, .crc_failures,
    .header_rejects, .seq_jump_total
  );

  // a good frame is never taken while an unread result would be overwritten
  assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> (!out_valid || out_ready)) else $error("result overwritten");
  // a byte is never taken while the CRC walk is in progress
  assert property (@(posedge clk) disable iff (rst)
    rx_ready |-> !cmd.crc_step) else $error("byte accepted during CRC walk");
  // result appears right after a frame is taken
  assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> out_valid) else $error("result missing");
endmodule
